/* rtl/sm4_pkg.sv */
// SM4 constants, S-box and round helper functions.
`default_nettype none
package sm4_pkg;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t w0;
		word_t w1;
		word_t w2;
		word_t w3;
	} block_t;

	localparam word_t FK0 = 32'hA3B1BAC6;
	localparam word_t FK1 = 32'h56AA3350;
	localparam word_t FK2 = 32'h677D9197;
	localparam word_t FK3 = 32'hB27022DC;

	localparam logic [1:0] REG_KEY0 = 2'd0;
	localparam logic [1:0] REG_KEY1 = 2'd1;
	localparam logic [1:0] REG_KEY2 = 2'd2;
	localparam logic [1:0] REG_KEY3 = 2'd3;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic word_t sub_word(input word_t v);
		sub_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	function automatic word_t rotl(input word_t v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	function automatic word_t data_mix(input word_t v);
		word_t b;
		b = sub_word(v);
		data_mix = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	function automatic word_t key_mix(input word_t v);
		word_t b;
		b = sub_word(v);
		key_mix = b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

	// byte j of CK[i] is (4i+j)*7 mod 256
	function automatic word_t round_const(input int i);
		word_t c;
		c = '0;
		for (int j = 0; j < 4; j++) begin
			c = {c[23:0], 8'(((4 * i) + j) * 7)};
		end
		round_const = c;
	endfunction

endpackage
`default_nettype wire

/* rtl/sm4_ifc.sv */
// Valid/ready channel interfaces for blocks and configuration writes.
`default_nettype none
interface sm4_block_if;
	import sm4_pkg::*;
	logic   valid;
	logic   ready;
	block_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sm4_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

/* rtl/sm4_block_encrypt_core.sv */
// SM4 encryption core: one round per pipeline stage, round keys run alongside.
//
// channel | dir | payload
// plain   | in  | data.w0..w3 = plain_word0..3
// cipher  | out | data.w0..w3 = cipher_word0..3
// cfg     | in  | index 0..3 selects key_word0..3, wdata
//
// One block per cycle sustained while cipher.ready is high.
// Each of the ROUND_COUNT stages holds one data round and one key round.
// Each stage advances when the stage after it is empty or advancing; bubbles
// are squeezed out. Reset clears the valid bits and key registers.
`default_nettype none
module sm4_block_encrypt_core
	import sm4_pkg::*;
#(
	parameter int ROUND_COUNT = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sm4_cfg_if.sink    cfg,
	sm4_block_if.sink  plain,
	sm4_block_if.source cipher
);

	word_t key_q [4];

	word_t x_s  [ROUND_COUNT+1][4];
	word_t k_s  [ROUND_COUNT+1][4];
	logic  vld_s [ROUND_COUNT+1];
	logic  adv  [ROUND_COUNT+1];

	block_t out_q;
	logic   out_vld_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_KEY0: key_q[0] <= cfg.wdata;
				REG_KEY1: key_q[1] <= cfg.wdata;
				REG_KEY2: key_q[2] <= cfg.wdata;
				REG_KEY3: key_q[3] <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// stage 0 is the input register
	always_comb begin
		adv[ROUND_COUNT] = !out_vld_q || cipher.ready;
		for (int i = ROUND_COUNT - 1; i >= 0; i--) begin
			adv[i] = !vld_s[i+1] || adv[i+1];
		end
	end
	assign plain.ready = !vld_s[0] || adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (plain.ready) begin
			vld_s[0] <= plain.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (plain.ready && plain.valid) begin
			x_s[0][0] <= plain.data.w0;
			x_s[0][1] <= plain.data.w1;
			x_s[0][2] <= plain.data.w2;
			x_s[0][3] <= plain.data.w3;
			k_s[0][0] <= key_q[0] ^ FK0;
			k_s[0][1] <= key_q[1] ^ FK1;
			k_s[0][2] <= key_q[2] ^ FK2;
			k_s[0][3] <= key_q[3] ^ FK3;
		end
	end

	for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
		word_t rk;
		word_t nx;
		assign rk = k_s[r][0] ^ key_mix(k_s[r][1] ^ k_s[r][2] ^ k_s[r][3] ^ round_const(r));
		assign nx = x_s[r][0] ^ data_mix(x_s[r][1] ^ x_s[r][2] ^ x_s[r][3] ^ rk);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[r+1] <= 1'b0;
			end else if (adv[r]) begin
				vld_s[r+1] <= vld_s[r];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[r] && vld_s[r]) begin
				x_s[r+1] <= '{x_s[r][1], x_s[r][2], x_s[r][3], nx};
				k_s[r+1] <= '{k_s[r][1], k_s[r][2], k_s[r][3], rk};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv[ROUND_COUNT]) begin
			out_vld_q <= vld_s[ROUND_COUNT];
		end
	end

	// output in reverse word order
	always_ff @(posedge clk) begin
		if (adv[ROUND_COUNT] && vld_s[ROUND_COUNT]) begin
			out_q.w0 <= x_s[ROUND_COUNT][3];
			out_q.w1 <= x_s[ROUND_COUNT][2];
			out_q.w2 <= x_s[ROUND_COUNT][1];
			out_q.w3 <= x_s[ROUND_COUNT][0];
		end
	end

	assign cipher.valid = out_vld_q;
	assign cipher.data  = out_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !cipher.ready |=> out_vld_q && $stable(out_q))
		else $error("result dropped while stalled");
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |-> plain.ready)
		else $error("input blocked with empty output");
	a_last_move: assert property (@(posedge clk) disable iff (!arst_n)
		adv[ROUND_COUNT] && vld_s[ROUND_COUNT] |=> out_vld_q)
		else $error("last stage transfer lost");

endmodule
`default_nettype wire

/* dv/sm4_block_encrypt_core_tb_ifc.sv */
// Testbench-side note: channel interfaces come from the RTL; this file holds shared test types.
`timescale 1ns / 100ps
package sm4_tb_pkg;
	import sm4_pkg::*;

	typedef struct {
		bit          is_key;
		logic [1:0]  index;
		word_t       wdata;
		block_t      blk;
	} plain_job_t;
endpackage

/* dv/tb_sm4_block_encrypt_core.sv */
// Self-checking testbench for the SM4 encryption core: queued stimulus, cipher predictor, scoreboard.
`timescale 1ns / 100ps
module tb_sm4_block_encrypt_core;
	import sm4_pkg::*;
	import sm4_tb_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk;
	logic arst_n;

	sm4_cfg_if   cfg();
	sm4_block_if plain();
	sm4_block_if cipher();

	sm4_block_encrypt_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.plain  (plain),
		.cipher (cipher)
	);

	logic [7:0] sbox_tb [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	word_t      key_shadow [4];
	plain_job_t job_q [$];
	block_t     cipher_q [$];
	bit         failed;
	bit         in_taken;
	bit         cfg_taken;
	int unsigned cycle_cnt;
	int unsigned send_gap;
	int unsigned recv_gap;
	int unsigned settle_cnt;

	function automatic word_t tau(word_t v);
		return {sbox_tb[v[31:24]], sbox_tb[v[23:16]], sbox_tb[v[15:8]], sbox_tb[v[7:0]]};
	endfunction

	function automatic word_t rol(word_t v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic block_t encrypt_block(block_t p);
		word_t k [4];
		word_t x [4];
		word_t ck, rk, t, nx;
		block_t c;
		k[0] = key_shadow[0] ^ 32'hA3B1BAC6;
		k[1] = key_shadow[1] ^ 32'h56AA3350;
		k[2] = key_shadow[2] ^ 32'h677D9197;
		k[3] = key_shadow[3] ^ 32'hB27022DC;
		x[0] = p.w0; x[1] = p.w1; x[2] = p.w2; x[3] = p.w3;
		for (int r = 0; r < 32; r++) begin
			for (int j = 0; j < 4; j++)
				ck[31 - 8 * j -: 8] = 8'((4 * r + j) * 7);
			t  = tau(k[1] ^ k[2] ^ k[3] ^ ck);
			rk = k[0] ^ t ^ rol(t, 13) ^ rol(t, 23);
			t  = tau(x[1] ^ x[2] ^ x[3] ^ rk);
			nx = x[0] ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
			k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = rk;
			x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
		end
		c.w0 = x[3]; c.w1 = x[2]; c.w2 = x[1]; c.w3 = x[0];
		return c;
	endfunction

	function automatic word_t rand_word(int mode);
		case (mode)
			0: return '0;
			1: return '1;
			2: return 32'h1 << $urandom_range(31, 0);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_key(word_t k0, word_t k1, word_t k2, word_t k3);
		plain_job_t j;
		word_t kv [4];
		kv = '{k0, k1, k2, k3};
		j.is_key = 1'b1;
		j.blk = '0;
		for (int i = 0; i < 4; i++) begin
			case (i)
				0: j.index = REG_KEY0;
				1: j.index = REG_KEY1;
				2: j.index = REG_KEY2;
				default: j.index = REG_KEY3;
			endcase
			j.wdata = kv[i];
			job_q.push_back(j);
		end
	endtask

	task automatic queue_block(word_t a, word_t b, word_t c, word_t d);
		plain_job_t j;
		j.is_key = 1'b0;
		j.index = REG_KEY0;
		j.wdata = '0;
		j.blk = '{w0: a, w1: b, w2: c, w3: d};
		job_q.push_back(j);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int m;
		arst_n = 1'b0;
		// published example: key and plaintext 0123456789abcdeffedcba9876543210
		queue_block(32'h0, 32'h0, 32'h0, 32'h0);
		queue_block('1, '1, '1, '1);
		queue_key(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
		queue_block(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
		queue_block(32'h80000000, 32'h0, 32'h0, 32'h1);
		queue_block(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
		queue_key('1, '1, '1, '1);
		queue_block('0, '0, '0, '0);
		queue_block('1, '1, '1, '1);
		queue_key(32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC);
		queue_block(32'h0, 32'h1, 32'h2, 32'h3);
		for (int ph = 0; ph < 8; ph++) begin
			m = $urandom_range(3, 0);
			queue_key(rand_word(m), rand_word(m), rand_word(3), rand_word(3));
			for (int n = 0; n < 105; n++) begin
				m = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 0) : 3;
				queue_block(rand_word(m), rand_word(3), rand_word(m), rand_word(3));
			end
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: a key write waits for an empty pipe and a settle period
	always @(negedge clk) begin
		plain_job_t j;
		logic       in_v;
		logic       cfg_v;
		in_v  = plain.valid && !in_taken;
		cfg_v = cfg.valid && !cfg_taken;
		if (!arst_n) begin
			in_v  = 1'b0;
			cfg_v = 1'b0;
		end else if (!in_v && !cfg_v) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (job_q.size() > 0) begin
				if (!job_q[0].is_key) begin
					j = job_q.pop_front();
					plain.data <= j.blk;
					in_v = 1'b1;
					send_gap <= ($urandom_range(3, 0) == 0) ?
						(($urandom_range(15, 0) == 0) ? $urandom_range(60, 10) :
						$urandom_range(3, 1)) : 0;
				end else if (cipher_q.size() > 0) begin
					settle_cnt <= DRAIN_CYCLES;
				end else if (settle_cnt > 0) begin
					settle_cnt <= settle_cnt - 1;
				end else begin
					j = job_q.pop_front();
					cfg.index <= j.index;
					cfg.wdata <= j.wdata;
					cfg_v = 1'b1;
				end
			end else if (cipher_q.size() > 0) begin
				settle_cnt <= DRAIN_CYCLES;
			end else if (settle_cnt > 0) begin
				settle_cnt <= settle_cnt - 1;
			end else begin
				if (!failed)
					$display("SCOREBOARD CLEAN");
				else
					$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
		plain.valid <= in_v;
		cfg.valid   <= cfg_v;
	end

	// sink stall pattern, changed on the falling edge
	always @(negedge clk) begin
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			cipher.ready <= 1'b0;
		end else if ($urandom_range(4, 0) == 0) begin
			recv_gap <= ($urandom_range(15, 0) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 0);
			cipher.ready <= 1'b0;
		end else
			cipher.ready <= 1'b1;
	end

	// monitor
	always @(posedge clk) begin
		block_t exp_blk;
		if (arst_n && cipher.valid && cipher.ready) begin
			if (cipher_q.size() == 0) begin
				$display("%0t: unexpected cipher transfer %h", $time, cipher.data);
				failed = 1'b1;
			end else begin
				exp_blk = cipher_q.pop_front();
				if (cipher.data.w0 !== exp_blk.w0 || cipher.data.w1 !== exp_blk.w1 ||
					cipher.data.w2 !== exp_blk.w2 || cipher.data.w3 !== exp_blk.w3) begin
					$display("%0t: cipher expected %h actual %h", $time, exp_blk, cipher.data);
					failed = 1'b1;
				end
			end
		end
		cfg_taken = arst_n && cfg.valid && cfg.ready;
		in_taken  = arst_n && plain.valid && plain.ready;
		if (cfg_taken)
			key_shadow[cfg.index] = cfg.wdata;
		if (in_taken)
			cipher_q.push_back(encrypt_block(plain.data));
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		failed = 1'b0;
		in_taken = 1'b0;
		cfg_taken = 1'b0;
		cycle_cnt = 0;
		send_gap = 0;
		recv_gap = 0;
		settle_cnt = 0;
		cfg.valid = 1'b0; cfg.index = '0; cfg.wdata = '0;
		plain.valid = 1'b0; plain.data = '0;
		cipher.ready = 1'b0;
		for (int i = 0; i < 4; i++) key_shadow[i] = '0;
	end
endmodule
